[src/set_assoc_tlb_hashed_lru_macros.svh]
// Assertion macros shared by the TLB RTL files.
// Plain text macros only; no dependencies.
`ifndef SET_ASSOC_TLB_HASHED_LRU_MACROS_SVH
`define SET_ASSOC_TLB_HASHED_LRU_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SATHL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SATHL_NEVER(lbl, clk, rstn, cond, msg) \
    `SATHL_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

[src/sathl_pkg.sv]
// Types, constants and the set index hash for the TLB tag store.
// No dependencies.
`default_nettype none

package sathl_pkg;

    localparam int VPN_W    = 52;
    localparam int PSHIFT_W = 4;
    localparam int CHUNK_W  = 43;
    localparam int SETIX_W  = 6;   // width of the set index in a result word
    localparam int SETMAX_W = 9;   // widest hashed index (512 sets)
    localparam int LIM_W    = 5;   // holds 0..16
    localparam int CFG_W    = 4;
    localparam int QDEPTH   = 2;
    localparam int CHUNK_LO = 9;   // 2MB chunk = vpn >> 9
    localparam int HASH_A   = 20;
    localparam int HASH_B   = 27;
    localparam int HASH_C   = 34;
    localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_FILL   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [VPN_W-1:0]    vpn;
        logic [PSHIFT_W-1:0] pshift;
        logic [CHUNK_W-1:0]  chunk;
        logic [SETMAX_W-1:0] set;
    } cmd_t;

    typedef struct packed {
        logic                evicted;
        logic [SETIX_W-1:0]  set_index;
        logic [PSHIFT_W-1:0] hit_shift;
        logic                hit;
    } res_t;

    // bit i = vpn[20+2i] ^ vpn[27+2i] ^ vpn[34+2i], for i below nbits
    function automatic logic [SETMAX_W-1:0] hash_set(input logic [VPN_W-1:0] vpn,
                                                     input int unsigned nbits);
        logic [SETMAX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SETMAX_W; i++) begin
            if (i < nbits) begin
                idx[i] = vpn[HASH_A + 2*i] ^ vpn[HASH_B + 2*i] ^ vpn[HASH_C + 2*i];
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[src/sathl_front.sv]
// Front end: takes input words, decodes the opcode and hashes the set index.
// Depends on sathl_pkg; feeds sathl_fifo.
`default_nettype none

module sathl_front #(
    parameter int SETS = 64
) (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [103:0]         s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 clearing,
    input  wire logic                 q_full,
    output logic                      q_push,
    output sathl_pkg::cmd_t           q_cmd
);

    localparam int unsigned HASH_BITS = $clog2(SETS + 1) - 1;

    logic [sathl_pkg::VPN_W-1:0] vpn;

    assign vpn      = s_tdata[51:0];
    assign s_tready = !q_full && !clearing;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_cmd        = '0;
        q_cmd.op     = sathl_pkg::op_t'(s_tuser);
        q_cmd.vpn    = vpn;
        q_cmd.pshift = s_tdata[55:52];
        q_cmd.chunk  = s_tdata[98:56];
        unique case (q_cmd.op) inside
            sathl_pkg::OP_LOOKUP, sathl_pkg::OP_FILL:
                q_cmd.set = sathl_pkg::hash_set(vpn, HASH_BITS);
            default:
                q_cmd.set = '0;
        endcase
    end

endmodule

`default_nettype wire

[src/sathl_fifo.sv]
// Two-entry command queue between the front end and the set engine.
// Depends on sathl_pkg.
`default_nettype none
`include "set_assoc_tlb_hashed_lru_macros.svh"

module sathl_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  sathl_pkg::cmd_t      din,
    output logic                 full,
    input  wire logic            pop,
    output sathl_pkg::cmd_t      dout,
    output logic                 empty
);

    sathl_pkg::cmd_t mem_reg [sathl_pkg::QDEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'(sathl_pkg::QDEPTH));
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `SATHL_NEVER(a_q_overflow, aclk, aresetn, push && full, "queue push while full")
    `SATHL_NEVER(a_q_underflow, aclk, aresetn, pop && empty, "queue pop while empty")
    `SATHL_ASSERT(a_q_count, aclk, aresetn, (push && !pop) |=> !empty, "queue lost a word")

endmodule

`default_nettype wire

[src/sathl_back.sv]
// Set engine: set memory, clearing pass, lookup, fill and flush, result register.
// Depends on sathl_pkg and the assertion macros; pops from sathl_fifo.
`default_nettype none
`include "set_assoc_tlb_hashed_lru_macros.svh"

module sathl_back #(
    parameter int SETS = 64,
    parameter int WAYS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [sathl_pkg::CFG_W-1:0]   ways_in_use,
    input  wire logic                          q_empty,
    input  sathl_pkg::cmd_t                    q_cmd,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output sathl_pkg::res_t                    m_res
);

    localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TW = sathl_pkg::VPN_W;
    localparam int SW = sathl_pkg::PSHIFT_W;
    localparam int LW = sathl_pkg::LIM_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FRD   = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    // set memory, one row per set
    logic [WAYS-1:0][TW-1:0] mem_tag   [SETS];
    logic [WAYS-1:0][SW-1:0] mem_shift [SETS];
    logic [WAYS-1:0]         mem_valid [SETS];
    logic [WAYS-1:0][RW-1:0] mem_rank  [SETS];

    logic [WAYS-1:0][TW-1:0] rd_tag_reg;
    logic [WAYS-1:0][SW-1:0] rd_shift_reg;
    logic [WAYS-1:0]         rd_valid_reg;
    logic [WAYS-1:0][RW-1:0] rd_rank_reg;

    state_t          state_reg, state_next;
    sathl_pkg::cmd_t cmd_reg, cmd_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   rd_addr;
    logic            out_valid_reg, out_valid_next;
    sathl_pkg::res_t out_reg, out_next;

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WAYS-1:0][TW-1:0] wr_tag;
    logic [WAYS-1:0][SW-1:0] wr_shift;
    logic [WAYS-1:0]         wr_valid;
    logic [WAYS-1:0][RW-1:0] wr_rank;

    // lookup
    logic [WAYS-1:0]         lk_match, lk_best;
    logic                    lk_hit;
    logic [RW-1:0]           lk_best_rank;
    logic [SW-1:0]           lk_best_shift;
    logic [WAYS-1:0][RW-1:0] lk_rank;
    // fill
    logic [LW-1:0]           fl_count, fl_limit;
    logic                    fl_evict;
    logic [WAYS-1:0]         fl_lru, fl_kept, fl_slot;
    logic [RW-1:0]           fl_lru_rank;
    logic                    fl_found;
    logic [WAYS-1:0][TW-1:0] fl_tag;
    logic [WAYS-1:0][SW-1:0] fl_shift;
    logic [WAYS-1:0][RW-1:0] fl_rank;
    // flush
    logic [WAYS-1:0]         fx_drop;
    logic [WAYS-1:0][RW-1:0] fx_rank;
    logic [TW-1:0]           fx_ent;
    logic [RW:0]             fx_gap;

    // lookup: most recent matching way wins and moves to the front
    always_comb begin
        lk_best_rank  = '0;
        lk_best_shift = '0;
        for (int w = 0; w < WAYS; w++) begin
            lk_match[w] = rd_valid_reg[w] && ((cmd_reg.vpn >> rd_shift_reg[w]) == rd_tag_reg[w]);
        end
        for (int w = 0; w < WAYS; w++) begin
            lk_best[w] = lk_match[w];
            for (int v = 0; v < WAYS; v++) begin
                if (v != w && lk_match[v] && rd_rank_reg[v] < rd_rank_reg[w]) begin
                    lk_best[w] = 1'b0;
                end
            end
        end
        lk_hit = |lk_best;
        for (int w = 0; w < WAYS; w++) begin
            if (lk_best[w]) begin
                lk_best_rank  = lk_best_rank | rd_rank_reg[w];
                lk_best_shift = lk_best_shift | rd_shift_reg[w];
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (lk_best[w]) begin
                lk_rank[w] = '0;
            end else if (lk_hit && rd_valid_reg[w] && rd_rank_reg[w] < lk_best_rank) begin
                lk_rank[w] = RW'(rd_rank_reg[w] + 1'b1);
            end else begin
                lk_rank[w] = rd_rank_reg[w];
            end
        end
    end

    // fill: evict LRU when at or over the limit, insert at MRU in the first free way
    always_comb begin
        fl_count    = '0;
        fl_lru_rank = '0;
        fl_found    = 1'b0;
        fl_slot     = '0;
        for (int w = 0; w < WAYS; w++) begin
            fl_count = fl_count + LW'(rd_valid_reg[w]);
        end
        if (ways_in_use == '0) begin
            fl_limit = LW'(1);
        end else if (LW'(ways_in_use) > LW'(WAYS)) begin
            fl_limit = LW'(WAYS);
        end else begin
            fl_limit = LW'(ways_in_use);
        end
        fl_evict = (fl_count >= fl_limit);
        for (int w = 0; w < WAYS; w++) begin
            fl_lru[w] = rd_valid_reg[w];
            for (int v = 0; v < WAYS; v++) begin
                if (v != w && rd_valid_reg[v] && rd_rank_reg[v] > rd_rank_reg[w]) begin
                    fl_lru[w] = 1'b0;
                end
            end
            if (fl_lru[w]) begin
                fl_lru_rank = fl_lru_rank | rd_rank_reg[w];
            end
        end
        fl_kept = rd_valid_reg & ~(fl_evict ? fl_lru : '0);
        for (int w = 0; w < WAYS; w++) begin
            if (!fl_kept[w] && !fl_found) begin
                fl_slot[w] = 1'b1;
                fl_found   = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            fl_tag[w]   = rd_tag_reg[w];
            fl_shift[w] = rd_shift_reg[w];
            fl_rank[w]  = rd_rank_reg[w];
            if (fl_slot[w]) begin
                fl_tag[w]   = cmd_reg.vpn >> cmd_reg.pshift;
                fl_shift[w] = cmd_reg.pshift;
                fl_rank[w]  = '0;
            end else if (fl_kept[w]) begin
                if (fl_evict && rd_rank_reg[w] > fl_lru_rank) begin
                    fl_rank[w] = rd_rank_reg[w];
                end else begin
                    fl_rank[w] = RW'(rd_rank_reg[w] + 1'b1);
                end
            end
        end
    end

    // flush: drop entries of the chunk, close the gaps in the order
    always_comb begin
        fx_ent = '0;
        for (int w = 0; w < WAYS; w++) begin
            fx_ent     = rd_tag_reg[w] << rd_shift_reg[w];
            fx_drop[w] = rd_valid_reg[w]
                      && (fx_ent[TW-1:sathl_pkg::CHUNK_LO] == cmd_reg.chunk);
        end
        for (int w = 0; w < WAYS; w++) begin
            fx_gap = '0;
            for (int v = 0; v < WAYS; v++) begin
                if (fx_drop[v] && rd_rank_reg[v] < rd_rank_reg[w]) begin
                    fx_gap = fx_gap + 1'b1;
                end
            end
            fx_rank[w] = RW'(rd_rank_reg[w] - fx_gap[RW-1:0]);
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_tag         = rd_tag_reg;
        wr_shift       = rd_shift_reg;
        wr_valid       = rd_valid_reg;
        wr_rank        = rd_rank_reg;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_valid = '0;
                wr_rank  = '0;
                addr_next = AW'(addr_reg + 1'b1);
                if (addr_reg == AW'(SETS - 1)) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = q_cmd.set[AW-1:0];
                if (!q_empty && (!out_valid_reg || m_tready)) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    addr_next  = rd_addr;
                    state_next = S_EXEC;
                end
            end
            S_FRD: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                out_next   = '0;
                state_next = S_IDLE;
                unique case (cmd_reg.op)
                    sathl_pkg::OP_LOOKUP: begin
                        wr_en              = 1'b1;
                        wr_rank            = lk_rank;
                        out_next.hit       = lk_hit;
                        out_next.hit_shift = lk_best_shift;
                        out_next.set_index = sathl_pkg::SETIX_W'(cmd_reg.set);
                        out_valid_next     = 1'b1;
                    end
                    sathl_pkg::OP_FILL: begin
                        wr_en              = 1'b1;
                        wr_tag             = fl_tag;
                        wr_shift           = fl_shift;
                        wr_valid           = fl_kept | fl_slot;
                        wr_rank            = fl_rank;
                        out_next.evicted   = fl_evict;
                        out_next.set_index = sathl_pkg::SETIX_W'(cmd_reg.set);
                        out_valid_next     = 1'b1;
                    end
                    sathl_pkg::OP_FLUSH: begin
                        wr_en    = 1'b1;
                        wr_valid = rd_valid_reg & ~fx_drop;
                        wr_rank  = fx_rank;
                        if (addr_reg == AW'(SETS - 1)) begin
                            out_valid_next = 1'b1;
                        end else begin
                            addr_next  = AW'(addr_reg + 1'b1);
                            state_next = S_FRD;
                        end
                    end
                    default: begin
                        out_valid_next = 1'b1;
                    end
                endcase
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_tag[wr_addr]   <= wr_tag;
            mem_shift[wr_addr] <= wr_shift;
            mem_valid[wr_addr] <= wr_valid;
            mem_rank[wr_addr]  <= wr_rank;
        end
        rd_tag_reg   <= mem_tag[rd_addr];
        rd_shift_reg <= mem_shift[rd_addr];
        rd_valid_reg <= mem_valid[rd_addr];
        rd_rank_reg  <= mem_rank[rd_addr];
    end

    assign clearing = (state_reg == S_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    `SATHL_ASSERT(a_pop_idle, aclk, aresetn, q_pop |-> (state_reg == S_IDLE), "pop outside idle")
    `SATHL_ASSERT(a_exec_result, aclk, aresetn,
        (state_reg == S_EXEC && cmd_reg.op != sathl_pkg::OP_FLUSH) |=> out_valid_reg,
        "lookup or fill gave no result")
    `SATHL_NEVER(a_wr_state, aclk, aresetn,
        wr_en && (state_reg == S_IDLE || state_reg == S_FRD), "set written while not busy")
    `SATHL_NEVER(a_pop_full, aclk, aresetn, q_pop && out_valid_reg && !m_tready,
        "new word started while result held")

endmodule

`default_nettype wire

[src/set_assoc_tlb_hashed_lru.sv]
// Set-associative TLB tag store with hashed set index and true LRU per set.
// After reset the block clears the valid bits of every set of its set memory and
// takes no input word meanwhile. A lookup or a fill then reads the set row from the
// set memory and then updates it and writes it back. A flush walks every set with
// the same read/write pair. A two-word queue in front and a result register behind
// let input and output stall on their own.
// Depends on sathl_pkg, sathl_front, sathl_fifo and sathl_back.
`default_nettype none

module set_assoc_tlb_hashed_lru #(
    parameter int SETS = 64,
    parameter int WAYS = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [3:0]    cfg_wr_data,   // ways_in_use
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [103:0]  s_tdata,       // vpn[51:0], pshift[55:52], chunk[98:56]
    input  wire logic [1:0]    s_tuser,       // opcode
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata        // hit, hit_shift, set_index, evicted
);

    logic [sathl_pkg::CFG_W-1:0] ways_reg;
    logic                        clearing;
    logic                        q_push, q_full, q_pop, q_empty;
    sathl_pkg::cmd_t             q_din, q_dout;
    sathl_pkg::res_t             res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg <= sathl_pkg::WAYS_RESET;
        end else if (cfg_wr_en) begin
            ways_reg <= cfg_wr_data;
        end
    end

    sathl_front #(.SETS(SETS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_din)
    );

    sathl_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    sathl_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ways_in_use (ways_reg),
        .q_empty     (q_empty),
        .q_cmd       (q_dout),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (res)
    );

    assign m_tdata = {4'b0000, res};

endmodule

`default_nettype wire

[test/set_assoc_tlb_hashed_lru_tb.sv]
// Self-checking testbench for the hashed-index, true-LRU TLB tag store.
// Drives lookup/fill/flush words, predicts results with a behavioural set model.
// Depends on sathl_pkg and set_assoc_tlb_hashed_lru.
`default_nettype none

module set_assoc_tlb_hashed_lru_tb;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int NIDX  = 6;

    typedef struct packed {
        sathl_pkg::op_t op;
        logic [51:0]    vpn;
        logic [3:0]     pshift;
        logic [42:0]    chunk;
    } tlb_req_t;

    // lowest bit first: hit, hit_shift, set_index, evicted
    typedef struct packed {
        logic       evicted;
        logic [5:0] set_index;
        logic [3:0] hit_shift;
        logic       hit;
    } tlb_rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [3:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [103:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    set_assoc_tlb_hashed_lru #(.SETS(NSETS), .WAYS(NWAYS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow TLB state
    logic [51:0] tag_m   [NSETS][NWAYS];
    logic [3:0]  shift_m [NSETS][NWAYS];
    logic        vld_m   [NSETS][NWAYS];
    int unsigned rank_m  [NSETS][NWAYS];
    int unsigned ways_lim;

    tlb_req_t pending_words[$];
    tlb_rsp_t expected_rsp[$];
    int       errors;
    int       rx_count;
    bit       hold_tx;
    bit       tx_took;     // word accepted at the last rising edge
    int       rx_hold;     // cycles left of a long receiver stall
    bit       rx_stall;
    int       burst_left, gap_left;
    int       rx_phase;

    // fill-addressable hot pages so lookups and flushes actually hit
    logic [51:0] hot_vpn [16];

    function automatic logic [5:0] set_of(logic [51:0] v);
        logic [5:0] s;
        for (int i = 0; i < NIDX; i++)
            s[i] = v[20+2*i] ^ v[27+2*i] ^ v[34+2*i];
        return s;
    endfunction

    function automatic void drop_way(int s, int w);
        int unsigned r;
        r = rank_m[s][w];
        vld_m[s][w] = 1'b0;
        for (int k = 0; k < NWAYS; k++)
            if (vld_m[s][k] && rank_m[s][k] > r) rank_m[s][k]--;
    endfunction

    function automatic tlb_rsp_t tlb_predict(tlb_req_t q);
        tlb_rsp_t r;
        int s, best, cnt, lru, slot, lim;
        bit found;
        logic [51:0] ent;
        r = '0;
        s = set_of(q.vpn);
        case (q.op)
            sathl_pkg::OP_LOOKUP: begin
                found = 0; best = 0;
                for (int w = 0; w < NWAYS; w++)
                    if (vld_m[s][w] && (q.vpn >> shift_m[s][w]) == tag_m[s][w])
                        if (!found || rank_m[s][w] < rank_m[s][best]) begin
                            found = 1; best = w;
                        end
                if (found) begin
                    for (int w = 0; w < NWAYS; w++)
                        if (vld_m[s][w] && rank_m[s][w] < rank_m[s][best]) rank_m[s][w]++;
                    rank_m[s][best] = 0;
                    r.hit = 1'b1;
                    r.hit_shift = shift_m[s][best];
                end
                r.set_index = 6'(s);
            end
            sathl_pkg::OP_FILL: begin
                lim = ways_lim < 1 ? 1 : (ways_lim > NWAYS ? NWAYS : ways_lim);
                cnt = 0; lru = -1; slot = -1;
                for (int w = 0; w < NWAYS; w++)
                    if (vld_m[s][w]) begin
                        cnt++;
                        if (lru < 0 || rank_m[s][w] > rank_m[s][lru]) lru = w;
                    end
                if (cnt >= lim && lru >= 0) begin
                    drop_way(s, lru);
                    r.evicted = 1'b1;
                end
                for (int w = 0; w < NWAYS; w++)
                    if (vld_m[s][w]) rank_m[s][w]++;
                    else if (slot < 0) slot = w;
                if (slot >= 0) begin
                    tag_m[s][slot]   = q.vpn >> q.pshift;
                    shift_m[s][slot] = q.pshift;
                    vld_m[s][slot]   = 1'b1;
                    rank_m[s][slot]  = 0;
                end
                r.set_index = 6'(s);
            end
            sathl_pkg::OP_FLUSH: begin
                for (int ss = 0; ss < NSETS; ss++)
                    for (int w = 0; w < NWAYS; w++)
                        if (vld_m[ss][w]) begin
                            ent = (tag_m[ss][w] << shift_m[ss][w]) >> 9;
                            if (ent[42:0] == q.chunk && ent[51:43] == '0) drop_way(ss, w);
                        end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic tlb_req_t rand_req(int mix);
        tlb_req_t q;
        logic [51:0] h;
        q.vpn    = 52'({$urandom, $urandom});
        q.pshift = 4'($urandom_range(0, 9));
        if ($urandom_range(0, 19) == 0) q.pshift = 4'($urandom_range(10, 15));
        q.chunk  = 43'({$urandom, $urandom});
        h = hot_vpn[$urandom_range(0, 15)];
        if ($urandom_range(0, 3) != 0) q.vpn = h ^ 52'($urandom_range(0, 1023));
        if ($urandom_range(0, 1) != 0) q.chunk = 43'(q.vpn >> 9);
        case ($urandom_range(0, 19)) inside
            [0:8]:   q.op = sathl_pkg::OP_LOOKUP;
            [9:16]:  q.op = sathl_pkg::OP_FILL;
            17:      q.op = sathl_pkg::OP_NONE;
            default: q.op = (mix > 0 || $urandom_range(0, 3) == 0) ? sathl_pkg::OP_FLUSH
                                                                   : sathl_pkg::OP_LOOKUP;
        endcase
        return q;
    endfunction

    task automatic push_req(sathl_pkg::op_t op, logic [51:0] v, logic [3:0] ps,
                            logic [42:0] ch);
        tlb_req_t q;
        q.op = op; q.vpn = v; q.pshift = ps; q.chunk = ch;
        pending_words = {pending_words, q};
    endtask

    task automatic drain_all();
        while (pending_words.size() != 0 || expected_rsp.size() != 0) @(posedge aclk);
        // a flush has finished walking the sets once its result is out
        repeat (2 * NSETS + 20) @(posedge aclk);
    endtask

    task automatic write_ways(logic [3:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        ways_lim = v;
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // sender: bursts and gaps, changes at falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tx_took) begin
            tx_took = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
                else begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = $urandom_range(0, 5);
                end
            end
            if (gap_left > 0 && burst_left == 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_tx) begin
                if (burst_left > 0) burst_left--;
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_words[0].chunk, pending_words[0].pshift,
                             pending_words[0].vpn};
                s_tuser  <= pending_words[0].op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // prediction on accept
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_rsp = {expected_rsp, tlb_predict(pending_words.pop_front())};
            tx_took = 1'b1;
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_phase = rx_phase + 1;
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_stall) begin
                rx_stall = 0;
                rx_hold = 150;
                m_tready <= 1'b0;
            end else if ((rx_phase / 64) % 3 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 9) > 3) && (rx_phase % 7 != 3);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        tlb_rsp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[11:0];
            rx_count++;
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                if (got.hit !== want.hit || got.hit_shift !== want.hit_shift ||
                    got.set_index !== want.set_index || got.evicted !== want.evicted ||
                    m_tdata[15:12] !== 4'b0) begin
                    $display("%0t: mismatch expected hit=%b shift=%0d set=%0d ev=%b,",
                             $time, want.hit, want.hit_shift, want.set_index, want.evicted,
                             " got hit=%b shift=%0d set=%0d ev=%b",
                             got.hit, got.hit_shift, got.set_index, got.evicted);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("set_assoc_tlb_hashed_lru_tb failed");
        $finish;
    end

    initial begin
        errors = 0; rx_count = 0; hold_tx = 0; tx_took = 0; rx_hold = 0; rx_stall = 0;
        burst_left = 0; gap_left = 0; rx_phase = 0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = sathl_pkg::OP_NONE; m_tready = 1'b0;
        ways_lim = sathl_pkg::WAYS_RESET;
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++) begin
                vld_m[s][w] = 0; rank_m[s][w] = 0; tag_m[s][w] = '0; shift_m[s][w] = '0;
            end
        for (int i = 0; i < 16; i++) hot_vpn[i] = 52'({$urandom, $urandom});
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, all ops, unused opcode, large shift, duplicates
        push_req(sathl_pkg::OP_LOOKUP, '0, 4'd0, '0);
        push_req(sathl_pkg::OP_FILL, '0, 4'd0, '0);
        push_req(sathl_pkg::OP_FILL, '0, 4'd0, '0);
        push_req(sathl_pkg::OP_LOOKUP, '0, 4'd0, '0);
        push_req(sathl_pkg::OP_FILL, '1, 4'd9, '1);
        push_req(sathl_pkg::OP_LOOKUP, '1, 4'd0, '1);
        push_req(sathl_pkg::OP_FILL, 52'h12345_6789A_BCD, 4'd15, '0);
        push_req(sathl_pkg::OP_LOOKUP, 52'h12345_6789A_BCD, 4'd0, '0);
        push_req(sathl_pkg::OP_NONE, '1, 4'hf, '1);
        push_req(sathl_pkg::OP_FLUSH, '0, 4'd0, 43'h0);
        push_req(sathl_pkg::OP_LOOKUP, '0, 4'd0, '0);
        push_req(sathl_pkg::OP_FLUSH, '0, 4'd0, '1);
        push_req(sathl_pkg::OP_LOOKUP, '1, 4'd0, '0);
        for (int i = 0; i < 9; i++)
            push_req(sathl_pkg::OP_FILL, hot_vpn[0] ^ 52'(i), 4'd0, '0);
        push_req(sathl_pkg::OP_LOOKUP, hot_vpn[0], 4'd0, '0);
        drain_all();

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_ways(4'd1);
                1: write_ways(4'd0);
                2: write_ways(4'd15);
                3: write_ways(4'd3);
                4: write_ways(4'd8);
                default: write_ways(4'd5);
            endcase
            for (int i = 0; i < 210; i++) pending_words = {pending_words, rand_req(ph % 2)};
            if (ph == 1) rx_stall = 1;
            if (ph == 3) begin
                while (pending_words.size() > 100) @(posedge aclk);
                hold_tx = 1;
                while (expected_rsp.size() != 0) @(posedge aclk);
                hold_tx = 0;
            end
            drain_all();
        end

        if (errors == 0)
            $display("set_assoc_tlb_hashed_lru_tb passed");
        else
            $display("set_assoc_tlb_hashed_lru_tb failed");
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/sathl_pkg.sv
src/sathl_front.sv
src/sathl_fifo.sv
src/sathl_back.sv
src/set_assoc_tlb_hashed_lru.sv
test/set_assoc_tlb_hashed_lru_tb.sv
